FILE: hdl/btm_pkg.sv
// Shared types and constants for the binary template matcher.
package btm_pkg;

  // Fixed field widths of one input beat.
  localparam int WordW   = 32;
  localparam int IdxW    = 5;
  localparam int BottomW = 20;
  localparam int OpW     = 2;

  // Configuration register widths.
  localparam int TplRowsW  = 6;
  localparam int TplWidthW = 9;
  localparam int RingRowsW = 6;
  localparam int CfgDataW  = 9;
  localparam int CfgIdxW   = 2;

  // Every image row is kept in this many bit-shifted copies.
  localparam int ShiftCopies = 32;

  // Walk counter widths: the register limits bound rows, words and columns.
  localparam int TplColW  = 4;
  localparam int ImgColW  = 6;
  localparam int WordsW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_TPL_WR = 2'd0,
    OP_IMG_WR = 2'd1,
    OP_MATCH  = 2'd2,
    OP_NONE   = 2'd3
  } btm_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TPL_ROWS  = 2'd0,
    CFG_TPL_WIDTH = 2'd1,
    CFG_RING_ROWS = 2'd2,
    CFG_UNUSED    = 2'd3
  } btm_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } btm_state_e;

  // Store write request, taken in the cycle a write beat is accepted.
  typedef struct packed {
    logic              tpl_we;
    logic              img_we;
    logic [IdxW-1:0]   row;
    logic [IdxW-1:0]   shift;
    logic [IdxW-1:0]   col;
    logic [WordW-1:0]  data;
  } btm_wr_req_t;

  // Store read request, one template word and one image word per cycle.
  typedef struct packed {
    logic                 en;
    logic [TplRowsW-1:0]  tpl_row;
    logic [TplColW-1:0]   tpl_col;
    logic [RingRowsW-1:0] img_row;
    logic [IdxW-1:0]      shift;
    logic [ImgColW-1:0]   img_col;
  } btm_rd_req_t;

  // Remainder unit request and response.
  typedef struct packed {
    logic                 start;
    logic [BottomW-1:0]   dividend;
    logic [RingRowsW-1:0] divisor;
  } btm_rem_req_t;

  typedef struct packed {
    logic                 done;
    logic [RingRowsW-1:0] rem;
  } btm_rem_rsp_t;

endpackage

FILE: hdl/binary_template_matcher_core.sv
// A write goes to the store in its accept cycle; a match walks rows * words word pairs, stopping early
// at the first differing word, with rows and words from the template size registers.
// The lead-in is the bit-serial remainder of the bottom row by the ring size;
// after it the walk reads one template word and one image word per cycle from the stores.
// Writes go back to back; after a match the next beat waits for its result in the output reg.
// Reset clears control and configuration only; both stores hold garbage until written.
module binary_template_matcher_core #(
  parameter int MAX_TEMPLATE_ROWS  = 32,
  parameter int MAX_TEMPLATE_WORDS = 8,
  parameter int RING_DEPTH         = 32,
  parameter int ROW_WORDS          = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [btm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [btm_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [btm_pkg::OpW-1:0]         operation_i,
  input  logic [btm_pkg::IdxW-1:0]        row_index_i,
  input  logic [btm_pkg::IdxW-1:0]        shift_index_i,
  input  logic [btm_pkg::IdxW-1:0]        word_column_i,
  input  logic [btm_pkg::WordW-1:0]       word_value_i,
  input  logic [btm_pkg::BottomW-1:0]     bottom_row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            matched_o
);
  import btm_pkg::*;

  localparam int MaxWidth = MAX_TEMPLATE_WORDS * 32;

  btm_state_e state_q, state_d;

  logic [TplRowsW-1:0]  tpl_rows_q;
  logic [TplWidthW-1:0] tpl_width_q;
  logic [RingRowsW-1:0] ring_rows_q;

  logic [TplRowsW-1:0]  rows;
  logic [TplWidthW-1:0] width;
  logic [RingRowsW-1:0] ring;
  logic [WordsW-1:0]    words;
  logic [WordW-1:0]     last_mask;
  logic [ImgColW-1:0]   col_end;
  logic                 col_fail;

  logic [IdxW-1:0]      shift_q, shift_d;
  logic [IdxW-1:0]      col_q, col_d;
  logic [TplRowsW-1:0]  r_q, r_d;
  logic [TplColW-1:0]   c_q, c_d;
  logic [RingRowsW-1:0] img_row_q, img_row_d;
  logic                 pend_q, pend_d;
  logic                 last_q, last_d;
  logic                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic                 matched_q, matched_d;

  logic                 accept;
  logic                 miss;
  logic                 row_end;

  btm_wr_req_t          wr_req;
  btm_rd_req_t          rd_req;
  btm_rem_req_t         rem_req;
  btm_rem_rsp_t         rem_rsp;
  logic [WordW-1:0]     tpl_rdata;
  logic [WordW-1:0]     img_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpl_rows_q  <= TplRowsW'(1);
      tpl_width_q <= TplWidthW'(32);
      ring_rows_q <= RingRowsW'(32);
    end else if (cfg_we_i) begin
      case (btm_cfg_e'(cfg_idx_i))
        CFG_TPL_ROWS:  tpl_rows_q  <= cfg_data_i[TplRowsW-1:0];
        CFG_TPL_WIDTH: tpl_width_q <= cfg_data_i[TplWidthW-1:0];
        CFG_RING_ROWS: ring_rows_q <= cfg_data_i[RingRowsW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate registers to their legal ranges.
  always_comb begin
    if (tpl_rows_q == '0) begin
      rows = TplRowsW'(1);
    end else if (32'(tpl_rows_q) > MAX_TEMPLATE_ROWS) begin
      rows = TplRowsW'(MAX_TEMPLATE_ROWS);
    end else begin
      rows = tpl_rows_q;
    end
    if (tpl_width_q == '0) begin
      width = TplWidthW'(1);
    end else if (32'(tpl_width_q) > MaxWidth) begin
      width = TplWidthW'(MaxWidth);
    end else begin
      width = tpl_width_q;
    end
    if (ring_rows_q == '0) begin
      ring = RingRowsW'(1);
    end else if (32'(ring_rows_q) > RING_DEPTH) begin
      ring = RingRowsW'(RING_DEPTH);
    end else begin
      ring = ring_rows_q;
    end
  end

  // Words per row, last-word mask, and the past-the-row check.
  always_comb begin
    logic [TplWidthW:0] wsum;
    wsum      = {1'b0, width} + (TplWidthW + 1)'(31);
    words     = wsum[TplWidthW:5];
    if (width[4:0] == '0) begin
      last_mask = '1;
    end else begin
      last_mask = ~({WordW{1'b1}} >> width[4:0]);
    end
    col_end  = ImgColW'(word_column_i) + ImgColW'(words);
    col_fail = 32'(col_end) > ROW_WORDS;
  end

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // Store writes go straight through in the accept cycle.
  assign wr_req.tpl_we = accept && (btm_op_e'(operation_i) == OP_TPL_WR);
  assign wr_req.img_we = accept && (btm_op_e'(operation_i) == OP_IMG_WR);
  assign wr_req.row    = row_index_i;
  assign wr_req.shift  = shift_index_i;
  assign wr_req.col    = word_column_i;
  assign wr_req.data   = word_value_i;

  // Compare the word pair read in the previous cycle.
  assign miss    = (img_rdata & (last_q ? last_mask : {WordW{1'b1}})) != tpl_rdata;
  assign row_end = ({1'b0, c_q} == (words - WordsW'(1)));

  // Sequencer: remainder lead-in, then walk rows bottom-up and words left to right.
  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    col_d       = col_q;
    r_d         = r_q;
    c_d         = c_q;
    img_row_d   = img_row_q;
    pend_d      = 1'b0;
    last_d      = last_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    matched_d   = matched_q;

    rem_req.start    = 1'b0;
    rem_req.dividend = bottom_row_i;
    rem_req.divisor  = ring;

    rd_req.en      = 1'b0;
    rd_req.tpl_row = r_q;
    rd_req.tpl_col = c_q;
    rd_req.img_row = img_row_q;
    rd_req.shift   = shift_q;
    rd_req.img_col = ImgColW'(col_q) + ImgColW'(c_q);

    case (state_q)
      ST_IDLE: begin
        if (accept && (btm_op_e'(operation_i) == OP_MATCH)) begin
          shift_d = shift_index_i;
          col_d   = word_column_i;
          r_d     = rows - TplRowsW'(1);
          c_d     = '0;
          if (col_fail) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            rem_req.start = 1'b1;
            state_d       = ST_REM;
          end
        end
      end
      ST_REM: begin
        if (rem_rsp.done) begin
          img_row_d = rem_rsp.rem;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (pend_q && miss) begin
          res_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          rd_req.en = 1'b1;
          pend_d    = 1'b1;
          last_d    = row_end;
          if (row_end) begin
            c_d = '0;
            r_d = r_q - TplRowsW'(1);
            if (img_row_q == '0) begin
              img_row_d = ring - RingRowsW'(1);
            end else begin
              img_row_d = img_row_q - RingRowsW'(1);
            end
            if (r_q == '0) begin
              state_d = ST_DRAIN;
            end
          end else begin
            c_d = c_q + TplColW'(1);
          end
        end
      end
      ST_DRAIN: begin
        res_d   = !(pend_q && miss);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          matched_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    col_q     <= col_d;
    r_q       <= r_d;
    c_q       <= c_d;
    img_row_q <= img_row_d;
    last_q    <= last_d;
    res_q     <= res_d;
    matched_q <= matched_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  btm_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  btm_mem #(
    .MAX_TEMPLATE_ROWS  (MAX_TEMPLATE_ROWS),
    .MAX_TEMPLATE_WORDS (MAX_TEMPLATE_WORDS),
    .RING_DEPTH         (RING_DEPTH),
    .ROW_WORDS          (ROW_WORDS)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_i        (wr_req),
    .rd_i        (rd_req),
    .tpl_rdata_o (tpl_rdata),
    .img_rdata_o (img_rdata)
  );

endmodule

FILE: hdl/btm_rem_unit.sv
// Bit-serial restoring remainder unit: bottom row modulo ring size.
module btm_rem_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btm_pkg::btm_rem_req_t req_i,
  output btm_pkg::btm_rem_rsp_t rsp_o
);
  import btm_pkg::*;

  localparam int CntW = $clog2(BottomW);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [BottomW-1:0]   dvd_q, dvd_d;
  logic [RingRowsW-1:0] div_q, div_d;
  logic [RingRowsW-1:0] rem_q, rem_d;
  logic [RingRowsW:0]   trial;

  // One quotient bit per cycle: shift in, compare, subtract.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[BottomW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(BottomW - 1);
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[BottomW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = RingRowsW'(trial - {1'b0, div_q});
      end else begin
        rem_d = RingRowsW'(trial);
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hdl/btm_mem.sv
// Template and image stores with one write port and a registered read each.
module btm_mem #(
  parameter int MAX_TEMPLATE_ROWS  = 32,
  parameter int MAX_TEMPLATE_WORDS = 8,
  parameter int RING_DEPTH         = 32,
  parameter int ROW_WORDS          = 32
) (
  input  logic                            clk_i,
  input  btm_pkg::btm_wr_req_t            wr_i,
  input  btm_pkg::btm_rd_req_t            rd_i,
  output logic [btm_pkg::WordW-1:0]       tpl_rdata_o,
  output logic [btm_pkg::WordW-1:0]       img_rdata_o
);
  import btm_pkg::*;

  localparam int TplRowAw = (MAX_TEMPLATE_ROWS > 1) ? $clog2(MAX_TEMPLATE_ROWS) : 1;
  localparam int TplColAw = (MAX_TEMPLATE_WORDS > 1) ? $clog2(MAX_TEMPLATE_WORDS) : 1;
  localparam int RingAw   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ColAw    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int ShiftAw  = $clog2(ShiftCopies);

  logic [WordW-1:0] tpl_mem [MAX_TEMPLATE_ROWS][MAX_TEMPLATE_WORDS];
  logic [WordW-1:0] img_mem [RING_DEPTH][ShiftCopies][ROW_WORDS];

  logic tpl_in_range;
  logic img_in_range;

  // Drop writes that land outside the stores.
  assign tpl_in_range = (32'(wr_i.row) < MAX_TEMPLATE_ROWS) &&
                        (32'(wr_i.col) < MAX_TEMPLATE_WORDS);
  assign img_in_range = (32'(wr_i.row) < RING_DEPTH) &&
                        (32'(wr_i.col) < ROW_WORDS);

  // Template store.
  always_ff @(posedge clk_i) begin
    if (wr_i.tpl_we && tpl_in_range) begin
      tpl_mem[TplRowAw'(wr_i.row)][TplColAw'(wr_i.col)] <= wr_i.data;
    end
    if (rd_i.en) begin
      tpl_rdata_o <= tpl_mem[TplRowAw'(rd_i.tpl_row)][TplColAw'(rd_i.tpl_col)];
    end
  end

  // Image store, one row per ring slot and shift copy.
  always_ff @(posedge clk_i) begin
    if (wr_i.img_we && img_in_range) begin
      img_mem[RingAw'(wr_i.row)][ShiftAw'(wr_i.shift)][ColAw'(wr_i.col)] <= wr_i.data;
    end
    if (rd_i.en) begin
      img_rdata_o <= img_mem[RingAw'(rd_i.img_row)][ShiftAw'(rd_i.shift)]
                            [ColAw'(rd_i.img_col)];
    end
  end

endmodule
